/* hw/rtl/rotation_matrix_to_quaternion_unit_macros.svh */
// assertion macros for the rotation matrix to quaternion unit
`ifndef ROTATION_MATRIX_TO_QUATERNION_UNIT_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_UNIT_MACROS_SVH

// property that holds from one clock to the next outside reset
`define RMQ_ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed: label");

// property that is checked during reset too
`define RMQ_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed: label");

`endif

/* hw/rtl/rmq_pkg.sv */
// ----------------------------------------------------------------------------
// rmq_pkg
// shared constants, types and helpers for the rotation matrix to quaternion unit
// ----------------------------------------------------------------------------
package rmq_pkg;

   localparam int RMQ_DATA_WIDTH = 32;
   localparam int RMQ_FRAC_BITS  = 30;
   localparam int RMQ_NUM_COMP   = 4;

   // component codes, also the tie order
   typedef enum logic [1:0] {
      COMP_X = 2'd0,
      COMP_Y = 2'd1,
      COMP_Z = 2'd2,
      COMP_W = 2'd3
   } comp_type;

   // sign request bits carried beside the roots
   typedef struct packed {
      logic xy_neg;  // m10 + m01 < 0
      logic xz_neg;  // m20 + m02 < 0
      logic yz_neg;  // m21 + m12 < 0
      logic xw_neg;  // m21 - m12 < 0
      logic yw_neg;  // m02 - m20 < 0
      logic zw_neg;  // m10 - m01 < 0
   } sign_type;

endpackage

/* hw/rtl/rmq_root_cell.sv */
// ----------------------------------------------------------------------------
// rmq_root_cell
// one step of a restoring square root: decides one result bit for one item
// ----------------------------------------------------------------------------
module rmq_root_cell
   import rmq_pkg::*;
#(
   parameter int RAD_WIDTH = 64,
   parameter int ROOT_WIDTH = 32,
   parameter int STEP = 0
) (
   input  logic                  clock,
   input  logic                  enable,
   input  logic [RAD_WIDTH-1:0]  rad_in,
   input  logic [RAD_WIDTH-1:0]  rem_in,
   input  logic [ROOT_WIDTH-1:0] root_in,
   output logic [RAD_WIDTH-1:0]  rad_out,
   output logic [RAD_WIDTH-1:0]  rem_out,
   output logic [ROOT_WIDTH-1:0] root_out
);

   // bit position decided by this cell
   localparam int BIT = ROOT_WIDTH - 1 - STEP;

   logic [RAD_WIDTH+1:0]  rem_shift;
   logic [RAD_WIDTH+1:0]  trial;
   logic [RAD_WIDTH+1:0]  diff;
   logic [RAD_WIDTH-1:0]  rem_ff, rem_in_nx;
   logic [RAD_WIDTH-1:0]  rad_ff;
   logic [ROOT_WIDTH-1:0] root_ff, root_nx;

   // remainder gets the next two radicand bits
   // trial is four times the partial root plus one, partial root taken from
   // the bits already decided above this position
   always_comb begin
      rem_shift = {rem_in, rad_in[2*BIT+1 -: 2]};
      trial = {{(RAD_WIDTH+2-ROOT_WIDTH-2){1'b0}}, root_in >> (BIT + 1), 2'b01};
      diff = rem_shift - trial;
      if (rem_shift >= trial) begin
         rem_in_nx = diff[RAD_WIDTH-1:0];
         root_nx = root_in | (ROOT_WIDTH'(1) << BIT);
      end else begin
         rem_in_nx = rem_shift[RAD_WIDTH-1:0];
         root_nx = root_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff <= rem_in_nx;
         root_ff <= root_nx;
         rad_ff <= rad_in;
      end
   end

   assign rad_out = rad_ff;
   assign rem_out = rem_ff;
   assign root_out = root_ff;

endmodule

/* hw/rtl/rmq_root_chain.sv */
// ----------------------------------------------------------------------------
// rmq_root_chain
// row of root cells for one component, one result bit per stage
// ----------------------------------------------------------------------------
module rmq_root_chain
   import rmq_pkg::*;
#(
   parameter int RAD_WIDTH = 64,
   parameter int ROOT_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  enable,
   input  logic [RAD_WIDTH-1:0]  radicand,
   output logic [ROOT_WIDTH-1:0] root
);

   logic [RAD_WIDTH-1:0]  rad_c  [ROOT_WIDTH+1];
   logic [RAD_WIDTH-1:0]  rem_c  [ROOT_WIDTH+1];
   logic [ROOT_WIDTH-1:0] root_c [ROOT_WIDTH+1];

   assign rad_c[0] = radicand;
   assign rem_c[0] = '0;
   assign root_c[0] = '0;

   for (genvar g = 0; g < ROOT_WIDTH; g++) begin : g_cell
      rmq_root_cell #(
         .RAD_WIDTH(RAD_WIDTH),
         .ROOT_WIDTH(ROOT_WIDTH),
         .STEP(g)
      ) u_cell (
         .clock(clock),
         .enable(enable),
         .rad_in(rad_c[g]),
         .rem_in(rem_c[g]),
         .root_in(root_c[g]),
         .rad_out(rad_c[g+1]),
         .rem_out(rem_c[g+1]),
         .root_out(root_c[g+1])
      );
   end

   assign root = root_c[ROOT_WIDTH];

endmodule

/* hw/rtl/rotation_matrix_to_quaternion_unit.sv */
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit
// converts a 3x3 rotation matrix in fixed point to a unit quaternion
// ----------------------------------------------------------------------------
// channel   ports          direction  contents
// req       req_valid/stall in        m00 .. m22, signed fixed point
// rsp       rsp_valid/stall out       quat_x .. quat_w, signed fixed point
//
// the chain of root cells decides one root bit per stage; data passes the sum registers,
// the radicand registers, the root cells and the output registers in that order
// one matrix per cycle is taken while the pipeline advances
// a stall on rsp while a result is valid freezes the whole pipeline; req_stall follows it
// reset clears the stage valid bits only
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_unit
   import rmq_pkg::*;
#(
   parameter int DATA_WIDTH = RMQ_DATA_WIDTH,
   parameter int FRAC_BITS  = RMQ_FRAC_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [DATA_WIDTH-1:0] req_m00,
   input  logic signed [DATA_WIDTH-1:0] req_m01,
   input  logic signed [DATA_WIDTH-1:0] req_m02,
   input  logic signed [DATA_WIDTH-1:0] req_m10,
   input  logic signed [DATA_WIDTH-1:0] req_m11,
   input  logic signed [DATA_WIDTH-1:0] req_m12,
   input  logic signed [DATA_WIDTH-1:0] req_m20,
   input  logic signed [DATA_WIDTH-1:0] req_m21,
   input  logic signed [DATA_WIDTH-1:0] req_m22,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_quat_x,
   output logic signed [DATA_WIDTH-1:0] rsp_quat_y,
   output logic signed [DATA_WIDTH-1:0] rsp_quat_z,
   output logic signed [DATA_WIDTH-1:0] rsp_quat_w
);

   // sums need two bits of growth over the elements plus the constant one
   localparam int SUM_WIDTH  = DATA_WIDTH + 3;
   localparam int MAG_WIDTH  = SUM_WIDTH - 1;
   // radicand is |s| << FRAC_BITS, rounded up to an even width
   localparam int RAD_RAW    = MAG_WIDTH + FRAC_BITS;
   localparam int RAD_WIDTH  = RAD_RAW + (RAD_RAW % 2);
   localparam int ROOT_WIDTH = RAD_WIDTH / 2;
   localparam int LAT        = ROOT_WIDTH + 3;
   localparam logic [ROOT_WIDTH-1:0] QMAX =
      ROOT_WIDTH'({1'b0, {(DATA_WIDTH-1){1'b1}}});

   logic adv;
   logic [LAT-1:0] vld_ff, vld_in;

   // the whole pipe moves together unless the output is held
   assign adv = !(vld_ff[LAT-1] && rsp_stall);
   assign req_stall = !adv;

   always_comb begin
      vld_in = {vld_ff[LAT-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // stage 0: diagonal sums and sign bits
   logic signed [SUM_WIDTH-1:0] d0, d1, d2, one_s;
   logic signed [SUM_WIDTH-1:0] s_in [RMQ_NUM_COMP];
   logic signed [SUM_WIDTH-1:0] s_ff [RMQ_NUM_COMP];
   sign_type sg_in;
   sign_type sg_pipe_ff [LAT-1];

   always_comb begin
      d0 = SUM_WIDTH'(req_m00);
      d1 = SUM_WIDTH'(req_m11);
      d2 = SUM_WIDTH'(req_m22);
      one_s = SUM_WIDTH'(1) <<< FRAC_BITS;
      s_in[COMP_X] = d0 - d1 - d2 + one_s;
      s_in[COMP_Y] = d1 - d0 - d2 + one_s;
      s_in[COMP_Z] = d2 - d0 - d1 + one_s;
      s_in[COMP_W] = d0 + d1 + d2 + one_s;
      sg_in.xy_neg = ((SUM_WIDTH'(req_m10) + SUM_WIDTH'(req_m01)) < 0);
      sg_in.xz_neg = ((SUM_WIDTH'(req_m20) + SUM_WIDTH'(req_m02)) < 0);
      sg_in.yz_neg = ((SUM_WIDTH'(req_m21) + SUM_WIDTH'(req_m12)) < 0);
      sg_in.xw_neg = ((SUM_WIDTH'(req_m21) - SUM_WIDTH'(req_m12)) < 0);
      sg_in.yw_neg = ((SUM_WIDTH'(req_m02) - SUM_WIDTH'(req_m20)) < 0);
      sg_in.zw_neg = ((SUM_WIDTH'(req_m10) - SUM_WIDTH'(req_m01)) < 0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < RMQ_NUM_COMP; k++) begin
            s_ff[k] <= s_in[k];
         end
         sg_pipe_ff[0] <= sg_in;
         for (int k = 1; k < LAT - 1; k++) begin
            sg_pipe_ff[k] <= sg_pipe_ff[k-1];
         end
      end
   end

   // stage 1: magnitude and scaling into the radicand, then the root chains
   logic [ROOT_WIDTH-1:0] root_c [RMQ_NUM_COMP];
   logic [MAG_WIDTH-1:0]  mag_c  [RMQ_NUM_COMP];
   logic [RAD_WIDTH-1:0]  rad_ff [RMQ_NUM_COMP];

   for (genvar c = 0; c < RMQ_NUM_COMP; c++) begin : g_comp
      always_comb begin
         mag_c[c] = s_ff[c][SUM_WIDTH-1] ? MAG_WIDTH'(-s_ff[c]) : MAG_WIDTH'(s_ff[c]);
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            rad_ff[c] <= RAD_WIDTH'(mag_c[c]) << FRAC_BITS;
         end
      end
      rmq_root_chain #(
         .RAD_WIDTH(RAD_WIDTH),
         .ROOT_WIDTH(ROOT_WIDTH)
      ) u_chain (
         .clock(clock),
         .enable(adv),
         .radicand(rad_ff[c]),
         .root(root_c[c])
      );
   end

   // last stage: halve, saturate, pick the largest, apply signs
   logic [ROOT_WIDTH-1:0] q_c [RMQ_NUM_COMP];
   logic [ROOT_WIDTH-1:0] best;
   comp_type idx;
   logic [RMQ_NUM_COMP-1:0] neg;
   sign_type sg_out;
   logic signed [DATA_WIDTH-1:0] qo_in [RMQ_NUM_COMP];
   logic signed [DATA_WIDTH-1:0] qo_ff [RMQ_NUM_COMP];

   assign sg_out = sg_pipe_ff[LAT-2];

   always_comb begin
      for (int k = 0; k < RMQ_NUM_COMP; k++) begin
         q_c[k] = root_c[k] >> 1;
         if (q_c[k] > QMAX) begin
            q_c[k] = QMAX;
         end
      end
      // strict compare keeps ties on the earlier component
      best = q_c[COMP_X];
      idx = COMP_X;
      if (q_c[COMP_Y] > best) begin
         best = q_c[COMP_Y];
         idx = COMP_Y;
      end
      if (q_c[COMP_Z] > best) begin
         best = q_c[COMP_Z];
         idx = COMP_Z;
      end
      if (q_c[COMP_W] > best) begin
         best = q_c[COMP_W];
         idx = COMP_W;
      end
      neg = '0;
      case (idx)
         COMP_X: begin
            neg[COMP_Y] = sg_out.xy_neg;
            neg[COMP_Z] = sg_out.xz_neg;
            neg[COMP_W] = sg_out.xw_neg;
         end
         COMP_Y: begin
            neg[COMP_X] = sg_out.xy_neg;
            neg[COMP_Z] = sg_out.yz_neg;
            neg[COMP_W] = sg_out.yw_neg;
         end
         COMP_Z: begin
            neg[COMP_X] = sg_out.xz_neg;
            neg[COMP_Y] = sg_out.yz_neg;
            neg[COMP_W] = sg_out.zw_neg;
         end
         default: begin
            neg[COMP_X] = sg_out.xw_neg;
            neg[COMP_Y] = sg_out.yw_neg;
            neg[COMP_Z] = sg_out.zw_neg;
         end
      endcase
      for (int k = 0; k < RMQ_NUM_COMP; k++) begin
         qo_in[k] = neg[k] ? -DATA_WIDTH'(q_c[k]) : DATA_WIDTH'(q_c[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < RMQ_NUM_COMP; k++) begin
            qo_ff[k] <= qo_in[k];
         end
      end
   end

   assign rsp_valid  = vld_ff[LAT-1];
   assign rsp_quat_x = qo_ff[COMP_X];
   assign rsp_quat_y = qo_ff[COMP_Y];
   assign rsp_quat_z = qo_ff[COMP_Z];
   assign rsp_quat_w = qo_ff[COMP_W];

endmodule

/* hw/rtl/rmq_checker.sv */
// ----------------------------------------------------------------------------
// rmq_checker
// port level checks for the rotation matrix to quaternion unit
// ----------------------------------------------------------------------------
`include "rotation_matrix_to_quaternion_unit_macros.svh"

module rmq_checker
   import rmq_pkg::*;
#(
   parameter int DATA_WIDTH = RMQ_DATA_WIDTH
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [DATA_WIDTH-1:0] rsp_quat_x,
   input logic [DATA_WIDTH-1:0] rsp_quat_w
);

   // a held result keeps its payload
   `RMQ_ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_quat_x) && $stable(rsp_quat_w))
   // input is stalled only while a result waits
   `RMQ_ASSERT_CLK(a_stall_cause, clock, reset, req_stall |-> rsp_valid && rsp_stall)
   // no result straight out of reset
   `RMQ_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid)
   // a free output never blocks the input
   `RMQ_ASSERT_CLK(a_no_block, clock, reset, !rsp_stall |-> !req_stall)

endmodule

bind rotation_matrix_to_quaternion_unit rmq_checker #(
   .DATA_WIDTH(DATA_WIDTH)
) u_rmq_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_quat_x(rsp_quat_x),
   .rsp_quat_w(rsp_quat_w)
);
